### rtl/core/sdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_pkg - shared types, constants and microcode for the cubic decimator
// Field widths, operand select codes, the control word layout and the
// read-only program that sequences the shared multiply/accumulate datapath.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int PHASE_BITS  = 24;
    localparam int INC_BITS    = PHASE_BITS + 1;
    localparam int MIX_BITS    = 17;
    localparam int TAPS        = 4;

    localparam logic [INC_BITS-1:0] PHASE_ONE = INC_BITS'(1) << PHASE_BITS;
    localparam logic [MIX_BITS-1:0] MIX_ONE   = MIX_BITS'(1) << (MIX_BITS - 1);

    // Datapath: 32-bit signed accumulator times 25-bit signed operand
    localparam int ACC_BITS   = 32;
    localparam int MUL_B_BITS = 25;
    localparam int PROD_BITS  = ACC_BITS + MUL_B_BITS;

    localparam int STEP_BITS  = 4;

    // Configuration register indexes
    localparam logic REG_PHASE_INC  = 1'b0;
    localparam logic REG_SMOOTH_MIX = 1'b1;

    // Multiplier second operand
    localparam logic MULB_FRAC = 1'b0;
    localparam logic MULB_MIX  = 1'b1;

    // Accumulator addend
    localparam logic [2:0] ADD_C3  = 3'd0;
    localparam logic [2:0] ADD_C2  = 3'd1;
    localparam logic [2:0] ADD_D20 = 3'd2;
    localparam logic [2:0] ADD_D10 = 3'd3;
    localparam logic [2:0] ADD_X0  = 3'd4;

    // Rounding shift of the registered product
    localparam logic [1:0] SH_24 = 2'd0;
    localparam logic [1:0] SH_25 = 2'd1;
    localparam logic [1:0] SH_16 = 2'd2;

    // Jump conditions
    localparam logic [1:0] COND_NONE        = 2'd0;
    localparam logic [1:0] COND_NO_ITEM     = 2'd1;
    localparam logic [1:0] COND_OUT_BLOCKED = 2'd2;

    typedef struct packed {
        logic                 mul_en;
        logic                 mul_b_sel;
        logic                 acc_en;
        logic                 coef_load;
        logic                 use_prod;
        logic [2:0]           add_sel;
        logic [1:0]           shift_sel;
        logic                 out_load;
        logic [1:0]           cond;
        logic                 last;
        logic [STEP_BITS-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic item;
        logic out_blocked;
    } seq_status_t;

    localparam ucode_t UC_NOP = '{
        mul_en: 1'b0, mul_b_sel: MULB_FRAC, acc_en: 1'b0, coef_load: 1'b0,
        use_prod: 1'b0, add_sel: ADD_C3, shift_sel: SH_24, out_load: 1'b0,
        cond: COND_NONE, last: 1'b0, target: '0
    };

    function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ucode_t w;
        w = UC_NOP;
        unique case (step)
            4'd0:
            begin
                w.cond   = COND_NO_ITEM;
                w.target = 4'd0;
            end
            4'd1:
            begin
                w.acc_en    = 1'b1;
                w.coef_load = 1'b1;
                w.add_sel   = ADD_C3;
            end
            4'd2:
            begin
                w.mul_en = 1'b1;
            end
            4'd3:
            begin
                w.acc_en    = 1'b1;
                w.use_prod  = 1'b1;
                w.add_sel   = ADD_C2;
                w.shift_sel = SH_24;
            end
            4'd4:
            begin
                w.mul_en = 1'b1;
            end
            4'd5:
            begin
                w.acc_en    = 1'b1;
                w.use_prod  = 1'b1;
                w.add_sel   = ADD_D20;
                w.shift_sel = SH_24;
            end
            4'd6:
            begin
                w.mul_en = 1'b1;
            end
            4'd7:
            begin
                w.acc_en    = 1'b1;
                w.use_prod  = 1'b1;
                w.add_sel   = ADD_D10;
                w.shift_sel = SH_25;
            end
            4'd8:
            begin
                w.mul_en    = 1'b1;
                w.mul_b_sel = MULB_MIX;
            end
            4'd9:
            begin
                w.use_prod  = 1'b1;
                w.add_sel   = ADD_X0;
                w.shift_sel = SH_16;
                w.out_load  = 1'b1;
                w.cond      = COND_OUT_BLOCKED;
                w.target    = 4'd9;
                w.last      = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/core/sdc_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_sequencer - microcode step counter
// Fetches one control word per step from the program table and branches on
// the waiting-for-item and output-blocked conditions.
// ----------------------------------------------------------------------------
module sdc_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdc_pkg::seq_status_t status,
    output sdc_pkg::ucode_t      ctl
);
    import sdc_pkg::*;

    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic                 cond_true;

    assign ctl = ucode_rom(step_reg);

    always_comb
    begin
        unique case (ctl.cond)
            COND_NO_ITEM:     cond_true = !status.item;
            COND_OUT_BLOCKED: cond_true = status.out_blocked;
            default:          cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (cond_true)
            step_next = ctl.target;
        else if (ctl.last)
            step_next = '0;
        else
            step_next = step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

endmodule

### rtl/core/sdc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_datapath - shared multiply, rounding shift and accumulate
// One signed multiplier with a registered product; the following step rounds
// the product half up, shifts it and adds a tap-derived addend.
// ----------------------------------------------------------------------------
module sdc_datapath (
    input  logic                                   clk,
    input  sdc_pkg::ucode_t                        ctl,
    input  logic signed [sdc_pkg::SAMPLE_BITS-1:0] x0,
    input  logic signed [sdc_pkg::SAMPLE_BITS-1:0] x1,
    input  logic signed [sdc_pkg::SAMPLE_BITS-1:0] x2,
    input  logic signed [sdc_pkg::SAMPLE_BITS-1:0] x3,
    input  logic        [sdc_pkg::PHASE_BITS-1:0]  frac,
    input  logic        [sdc_pkg::MIX_BITS-1:0]    mix,
    output logic signed [sdc_pkg::SAMPLE_BITS-1:0] result
);
    import sdc_pkg::*;

    localparam logic signed [PROD_BITS-1:0] RND_16 = PROD_BITS'(1) << 15;
    localparam logic signed [PROD_BITS-1:0] RND_24 = PROD_BITS'(1) << 23;
    localparam logic signed [PROD_BITS-1:0] RND_25 = PROD_BITS'(1) << 24;
    localparam logic signed [ACC_BITS-1:0]  SAT_MAX =
        (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0]  SAT_MIN = ~SAT_MAX;

    logic signed [ACC_BITS-1:0]   x0e, x1e, x2e, x3e;
    logic signed [ACC_BITS-1:0]   d12, c3, c2;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [PROD_BITS-1:0]  product;
    logic signed [PROD_BITS-1:0]  rnd_const, rounded_sum, shifted_full;
    logic signed [ACC_BITS-1:0]   addend, acc_next;

    logic signed [ACC_BITS-1:0]   acc_reg;
    logic signed [ACC_BITS-1:0]   c2_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;

    assign x0e = ACC_BITS'(x0);
    assign x1e = ACC_BITS'(x1);
    assign x2e = ACC_BITS'(x2);
    assign x3e = ACC_BITS'(x3);

    assign d12 = x1e - x2e;
    assign c3  = (d12 <<< 1) + d12 - x0e + x3e;
    assign c2  = (x2e <<< 2) + (x0e <<< 1) - (x1e <<< 2) - x1e - x3e;

    always_comb
    begin
        unique case (ctl.mul_b_sel)
            MULB_MIX:  mul_b = $signed({{(MUL_B_BITS - MIX_BITS){1'b0}}, mix});
            default:   mul_b = $signed({{(MUL_B_BITS - PHASE_BITS){1'b0}}, frac});
        endcase
    end

    assign product = acc_reg * mul_b;

    always_comb
    begin
        unique case (ctl.shift_sel)
            SH_16:   rnd_const = RND_16;
            SH_25:   rnd_const = RND_25;
            default: rnd_const = RND_24;
        endcase
    end

    assign rounded_sum = prod_reg + rnd_const;

    always_comb
    begin
        unique case (ctl.shift_sel)
            SH_16:   shifted_full = rounded_sum >>> 16;
            SH_25:   shifted_full = rounded_sum >>> 25;
            default: shifted_full = rounded_sum >>> 24;
        endcase
    end

    always_comb
    begin
        unique case (ctl.add_sel)
            ADD_C3:  addend = c3;
            ADD_C2:  addend = c2_reg;
            ADD_D20: addend = x2e - x0e;
            ADD_D10: addend = x1e - x0e;
            ADD_X0:  addend = x0e;
            default: addend = '0;
        endcase
    end

    assign acc_next = addend + (ctl.use_prod ? shifted_full[ACC_BITS-1:0] : '0);

    always_comb
    begin
        priority if (acc_next > SAT_MAX)
            result = SAT_MAX[SAMPLE_BITS-1:0];
        else if (acc_next < SAT_MIN)
            result = SAT_MIN[SAMPLE_BITS-1:0];
        else
            result = acc_next[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
            prod_reg <= product;
        if (ctl.acc_en)
            acc_reg <= acc_next;
        if (ctl.coef_load)
            c2_reg <= c2;
    end

endmodule

### rtl/core/smooth_decimator_cubic_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_decimator_cubic_core - phase-driven decimator with cubic smoothing
// Advances a fractional phase per sample, shifts the sample into a four-tap
// history on each wrap, and returns a blend of the oldest tap and a cubic
// interpolation across the taps, saturated to the sample range.
// ----------------------------------------------------------------------------
//   channel  handshake                     payload
//   input    in_valid / in_stall           sample_in   (24b signed)
//   output   out_valid / out_stall         sample_out  (24b signed)
//   config   psel penable pwrite pready    paddr pwdata prdata
//
// An item runs through the accept step and then nine microcode steps that
// share one 32x25 multiplier, each product registered before its rounding add.
// The next item is taken once the sequencer is back at step 0.
// A result held by out_stall keeps the sequencer at its last step.
// Reset clears phase and history and loads both registers with one.
// ----------------------------------------------------------------------------
module smooth_decimator_cubic_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [sdc_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [sdc_pkg::SAMPLE_BITS-1:0] sample_out,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import sdc_pkg::*;

    logic [INC_BITS-1:0]          phase_inc_reg;
    logic [MIX_BITS-1:0]          smooth_mix_reg;
    logic [PHASE_BITS-1:0]        phase_accum_reg;
    logic signed [SAMPLE_BITS-1:0] hist_reg [TAPS];
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic [INC_BITS-1:0]           inc_eff;
    logic [MIX_BITS-1:0]           mix_eff;
    logic [INC_BITS-1:0]           phase_sum;
    logic                          cfg_write;
    logic                          accept;
    logic                          out_blocked;
    logic                          out_load;
    logic signed [SAMPLE_BITS-1:0] result;
    ucode_t                        ctl;
    seq_status_t                   status;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_PHASE_INC:  prdata = 32'(phase_inc_reg);
            default:        prdata = 32'(smooth_mix_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg  <= PHASE_ONE;
            smooth_mix_reg <= MIX_ONE;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_PHASE_INC)
                phase_inc_reg <= pwdata[INC_BITS-1:0];
            else
                smooth_mix_reg <= pwdata[MIX_BITS-1:0];
        end
    end

    // Clamp both settings to one
    assign inc_eff = (phase_inc_reg > PHASE_ONE) ? PHASE_ONE : phase_inc_reg;
    assign mix_eff = (smooth_mix_reg > MIX_ONE) ? MIX_ONE : smooth_mix_reg;

    // Input side
    assign in_stall  = (ctl.cond != COND_NO_ITEM);
    assign accept    = in_valid && !in_stall;
    assign phase_sum = INC_BITS'(phase_accum_reg) + inc_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_accum_reg <= '0;
            for (int i = 0; i < TAPS; i++)
                hist_reg[i] <= '0;
        end
        else if (accept)
        begin
            phase_accum_reg <= phase_sum[PHASE_BITS-1:0];
            // wrap past one: shift the sample into the history
            if (phase_sum[PHASE_BITS])
            begin
                for (int i = 0; i < TAPS - 1; i++)
                    hist_reg[i] <= hist_reg[i+1];
                hist_reg[TAPS-1] <= sample_in;
            end
        end
    end

    // Output side
    assign out_blocked = out_valid_reg && out_stall;
    assign out_load    = ctl.out_load && !out_blocked;
    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            sample_out_reg <= result;
    end

    assign status.item        = in_valid;
    assign status.out_blocked = out_blocked;

    sdc_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    sdc_datapath u_dp (
        .clk    (clk),
        .ctl    (ctl),
        .x0     (hist_reg[0]),
        .x1     (hist_reg[1]),
        .x2     (hist_reg[2]),
        .x3     (hist_reg[3]),
        .frac   (phase_accum_reg),
        .mix    (mix_eff),
        .result (result)
    );

    // Assertions
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("sequencer idle right after an accepted transfer");

    a_phase_held_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(phase_accum_reg))
        else $error("phase moved while an item was being processed");

    a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !in_stall == 1'b0)
        else $error("result loaded while sequencer was waiting for input");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(sample_out_reg))
        else $error("held result overwritten");

endmodule
